/* hdl/fan_tach_speed_and_drive_macros.svh */
// Assertion macros for the fan tach speed and drive port checker.
`ifndef FAN_TACH_SPEED_AND_DRIVE_MACROS_SVH
`define FAN_TACH_SPEED_AND_DRIVE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FTS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fts_pkg.sv */
// Types, constants and codes shared by the fan tach speed and drive block.
package fts_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int HIST_FILL_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int AGE_W         = 6;
  localparam int CMP_W         = ((HIST_FILL_W > AGE_W) ? HIST_FILL_W : AGE_W) + 1;
  localparam int COUNT_W       = 7;
  localparam int COUNT_MAX     = 127;

  localparam int REG_W     = 16;
  localparam int US_W      = 32;
  localparam int SEC_W     = 23;
  localparam int SPEED_W   = 16;
  localparam int POWER_W   = 16;
  localparam int PULSE_W   = 32;
  localparam int TICK_W    = 16;

  localparam int SAMPLE_PERIOD_RST = 100;
  localparam int START_POWER_RST   = 50;

  localparam int SPEED_SCALE    = 30000000;
  localparam int SCALE_W        = $clog2(SPEED_SCALE);
  localparam int PROD_W         = PULSE_W + SCALE_W;
  localparam int SLOW_SPEED     = 50;
  localparam int SPEED_MAX      = (1 << SPEED_W) - 1;

  localparam int PERIOD_DIVISOR = 10;
  localparam int RECIP_SHIFT    = 19;
  localparam int RECIP_MUL      = ((1 << RECIP_SHIFT) + PERIOD_DIVISOR - 1) / PERIOD_DIVISOR;
  localparam int RECIP_W        = REG_W + REG_W;

  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIV_W     = US_W;

  typedef enum logic [1:0] {
    OP_TACH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_POWER = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_SAMPLE_PERIOD = 1'b0,
    CFG_START_POWER   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_PROD,
    ST_SPD_START,
    ST_SPD_WAIT,
    ST_PUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     rem_init;
    logic [DIV_STEPS-1:0] low;
    logic [DIV_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_STEPS-1:0] quot;
    logic [DIV_W-1:0]     rem;
  } div_rsp_t;

  typedef struct packed {
    logic [SEC_W-1:0]   tstamp;
    logic [SPEED_W-1:0] speed;
  } hist_entry_t;

  typedef struct packed {
    logic [POWER_W-1:0] drive_power;
    logic [SPEED_W-1:0] speed_rpm;
    logic [SEC_W-1:0]   hist_time;
    logic [SPEED_W-1:0] hist_speed;
    logic               hist_valid;
    logic [COUNT_W-1:0] hist_count;
  } out_item_t;

endpackage

/* hdl/fts_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
interface fts_in_if;
  import fts_pkg::*;

  logic               valid;
  logic               ready;
  op_e                op;
  logic               tach_low;
  logic [US_W-1:0]    now_us;
  logic [SEC_W-1:0]   now_s;
  logic [POWER_W-1:0] power_request;
  logic [AGE_W-1:0]   history_index;

  modport source (
    output valid, op, tach_low, now_us, now_s, power_request, history_index,
    input  ready
  );
  modport sink (
    input  valid, op, tach_low, now_us, now_s, power_request, history_index,
    output ready
  );
endinterface

interface fts_out_if;
  import fts_pkg::*;

  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] drive_power;
  logic [SPEED_W-1:0] speed_rpm;
  logic [SEC_W-1:0]   hist_time;
  logic [SPEED_W-1:0] hist_speed;
  logic               hist_valid;
  logic [COUNT_W-1:0] hist_count;

  modport source (
    output valid, drive_power, speed_rpm, hist_time, hist_speed, hist_valid, hist_count,
    input  ready
  );
  modport sink (
    input  valid, drive_power, speed_rpm, hist_time, hist_speed, hist_valid, hist_count,
    output ready
  );
endinterface

/* hdl/fan_tach_speed_and_drive.sv */
// Top level of the fan tach speed monitor, drive clamp and speed history.
//
// One input transaction on in_if yields exactly one result transaction on
// out_if. Tach edge, set power and read history go from ST_IDLE to ST_FIN,
// where the result is loaded into the output register once it is free.
// A speed tick runs a 16-step bit-serial remainder to find the speed tick
// boundary; when a speed is due, a second 16-step division of pulses times
// 30000000 by the elapsed microseconds follows, unless the speed saturates.
// One transaction is in progress at a time, and in_if.ready is high only
// while the block waits for one. Results sit in an output register, so the
// next transaction is accepted while a result still waits for out_if.ready;
// a stalled receiver holds the result stable and stalls the block only once
// the next result is ready. The user must write registers through cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle; the block itself
// does not enforce this. Reset restores sample_period 100 and start_power
// 50, clears counters, speed and power, and leaves one zero entry in the
// history.
module fan_tach_speed_and_drive (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  fts_pkg::cfg_reg_e        cfg_idx_i,
  input  logic [fts_pkg::REG_W-1:0] cfg_data_i,
  fts_in_if.sink                   in_if,
  fts_out_if.source                out_if
);
  import fts_pkg::*;

  state_e state_q, state_d;

  logic [REG_W-1:0]       sample_period_q;
  logic [REG_W-1:0]       start_power_q;
  logic [TICK_W-1:0]      tick_q;
  logic [PULSE_W-1:0]     pulse_q;
  logic [US_W-1:0]        last_q;
  logic [SPEED_W-1:0]     speed_q;
  logic [POWER_W-1:0]     power_q;
  logic [HIST_AW-1:0]     head_q;
  logic [HIST_FILL_W-1:0] fill_q;
  logic                   zero_wr_q;
  logic                   out_valid_q;

  op_e                    op_q;
  logic [US_W-1:0]        now_us_q;
  logic [SEC_W-1:0]       now_s_q;
  logic [REG_W-1:0]       step_q;
  logic [PROD_W-1:0]      prod_q;
  logic [US_W-1:0]        interval_q;
  hist_entry_t            rd_data_q;
  logic                   rd_valid_q;
  logic                   rd_zero_q;
  out_item_t              out_q;

  hist_entry_t            hist_mem [HISTORY_DEPTH];

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic                   accept;
  logic                   sat;
  logic                   push;
  logic                   load_out;
  logic [HIST_AW-1:0]     head_nxt;
  logic [RECIP_W-1:0]     recip;
  logic [REG_W-1:0]       step_raw;
  logic [CMP_W-1:0]       age_w;
  logic [CMP_W-1:0]       head_w;
  logic [CMP_W-1:0]       fill_w;
  logic [CMP_W-1:0]       addr_w;
  logic [HIST_AW-1:0]     rd_addr;
  logic [POWER_W-1:0]     req_clamped;
  logic [COUNT_W-1:0]     count_sat;

  fts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept   = in_if.valid && in_if.ready;
  assign sat      = (prod_q[PROD_W-1:DIV_STEPS] >= (PROD_W - DIV_STEPS)'(interval_q));
  assign push     = (state_q == ST_PUSH) && (tick_q == sample_period_q);
  assign head_nxt = (head_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || out_if.ready);

  assign recip    = RECIP_W'(sample_period_q) * RECIP_W'(RECIP_MUL);
  assign step_raw = REG_W'(recip >> RECIP_SHIFT);

  assign age_w   = CMP_W'(in_if.history_index);
  assign head_w  = CMP_W'(head_q);
  assign fill_w  = CMP_W'(fill_q);
  assign addr_w  = (head_w >= age_w) ? (head_w - age_w)
                                     : (head_w + CMP_W'(HISTORY_DEPTH) - age_w);
  assign rd_addr = addr_w[HIST_AW-1:0];

  assign req_clamped = ((in_if.power_request != '0) &&
                        (speed_q < SPEED_W'(SLOW_SPEED)) &&
                        (in_if.power_request < start_power_q)) ? start_power_q
                                                               : in_if.power_request;

  assign count_sat = (fill_q > HIST_FILL_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                        : COUNT_W'(fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_if.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.low      = tick_q;
    div_req.divisor  = DIV_W'(step_q);
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_d = (in_if.op == OP_TICK) ? ST_MOD_START : ST_FIN;
        end
      end
      ST_MOD_START: begin
        div_req.start = 1'b1;
        state_d       = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.rem == '0) ? ST_PROD : ST_PUSH;
        end
      end
      ST_PROD: begin
        state_d = ST_SPD_START;
      end
      ST_SPD_START: begin
        div_req.rem_init = prod_q[DIV_STEPS+DIV_W-1:DIV_STEPS];
        div_req.low      = prod_q[DIV_STEPS-1:0];
        div_req.divisor  = interval_q;
        if (sat) begin
          state_d = ST_PUSH;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_SPD_WAIT;
        end
      end
      ST_SPD_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= REG_W'(SAMPLE_PERIOD_RST);
      start_power_q   <= REG_W'(START_POWER_RST);
      tick_q          <= '0;
      pulse_q         <= '0;
      last_q          <= '0;
      speed_q         <= '0;
      power_q         <= '0;
      head_q          <= '0;
      fill_q          <= HIST_FILL_W'(1);
      zero_wr_q       <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i;
          CFG_START_POWER:   start_power_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (accept) begin
        case (in_if.op)
          OP_TACH:  pulse_q <= pulse_q + PULSE_W'(in_if.tach_low);
          OP_TICK:  tick_q  <= tick_q + 1'b1;
          OP_POWER: power_q <= req_clamped;
          default: begin
          end
        endcase
      end
      if (state_q == ST_PROD) begin
        last_q  <= now_us_q;
        pulse_q <= '0;
      end
      if ((state_q == ST_SPD_START) && sat) begin
        speed_q <= SPEED_W'(SPEED_MAX);
      end
      if ((state_q == ST_SPD_WAIT) && div_rsp.done) begin
        speed_q <= div_rsp.quot;
      end
      if (push) begin
        tick_q <= '0;
        head_q <= head_nxt;
        if (fill_q < HIST_FILL_W'(HISTORY_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        if (head_nxt == '0) begin
          zero_wr_q <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= in_if.op;
      now_us_q   <= in_if.now_us;
      now_s_q    <= in_if.now_s;
      step_q     <= (step_raw == '0) ? REG_W'(1) : step_raw;
      rd_valid_q <= (age_w < fill_w);
      rd_zero_q  <= (rd_addr == '0) && !zero_wr_q;
    end
    if (state_q == ST_PROD) begin
      prod_q     <= PROD_W'(pulse_q) * PROD_W'(SPEED_SCALE);
      interval_q <= now_us_q - last_q;
    end
    if (load_out) begin
      out_q.drive_power <= power_q;
      out_q.speed_rpm   <= speed_q;
      out_q.hist_valid  <= (op_q == OP_READ) && rd_valid_q;
      out_q.hist_count  <= count_sat;
      if ((op_q == OP_READ) && rd_valid_q && !rd_zero_q) begin
        out_q.hist_time  <= rd_data_q.tstamp;
        out_q.hist_speed <= rd_data_q.speed;
      end else begin
        out_q.hist_time  <= '0;
        out_q.hist_speed <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      hist_mem[head_nxt] <= '{tstamp: now_s_q, speed: speed_q};
    end
    if (accept && (in_if.op == OP_READ)) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.drive_power = out_q.drive_power;
  assign out_if.speed_rpm   = out_q.speed_rpm;
  assign out_if.hist_time   = out_q.hist_time;
  assign out_if.hist_speed  = out_q.hist_speed;
  assign out_if.hist_valid  = out_q.hist_valid;
  assign out_if.hist_count  = out_q.hist_count;

endmodule

/* hdl/fts_div.sv */
// Bit-serial restoring divider producing one quotient bit per cycle.
module fts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fts_pkg::div_req_t req_i,
  output fts_pkg::div_rsp_t rsp_o
);
  import fts_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q;
  logic [DIV_W-1:0]     dvsr_q;
  logic [DIV_STEPS-1:0] shf_q;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  assign trial = {rem_q, shf_q[DIV_STEPS-1]};
  assign fits  = (trial >= {1'b0, dvsr_q});
  assign diff  = trial - {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      shf_q  <= req_i.low;
      dvsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      shf_q <= {shf_q[DIV_STEPS-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = shf_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* hdl/fts_checker.sv */
// Port-level assertion checker for the fan tach speed and drive block.
`include "fan_tach_speed_and_drive_macros.svh"

module fts_port_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [fts_pkg::POWER_W-1:0]     out_drive_power_i,
  input logic [fts_pkg::SPEED_W-1:0]     out_speed_rpm_i,
  input logic [fts_pkg::SEC_W-1:0]       out_hist_time_i,
  input logic [fts_pkg::SPEED_W-1:0]     out_hist_speed_i,
  input logic                            out_hist_valid_i,
  input logic [fts_pkg::COUNT_W-1:0]     out_hist_count_i
);
  import fts_pkg::*;

  // A stalled result must keep its payload until the receiver takes it.
  `FTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable({out_drive_power_i, out_speed_rpm_i,
                   out_hist_time_i, out_hist_speed_i, out_hist_valid_i, out_hist_count_i}),
                   "result changed while stalled")

  // Only one transaction is in progress, so ready drops right after acceptance.
  `FTS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i,
                   !in_ready_i, "input accepted while busy")

  // The history always holds between one entry and its full depth.
  `FTS_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_valid_i,
                  (out_hist_count_i != '0) && (out_hist_count_i <= COUNT_W'(HISTORY_DEPTH)),
                  "history count out of range")

  // A result without a history entry reports zero time and speed.
  `FTS_ASSERT_NOW(a_hist_zero, clk_i, rst_ni, out_valid_i && !out_hist_valid_i,
                  (out_hist_time_i == '0) && (out_hist_speed_i == '0),
                  "history fields set without entry")

endmodule

bind fan_tach_speed_and_drive fts_port_checker u_fts_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_drive_power_i (out_if.drive_power),
  .out_speed_rpm_i   (out_if.speed_rpm),
  .out_hist_time_i   (out_if.hist_time),
  .out_hist_speed_i  (out_if.hist_speed),
  .out_hist_valid_i  (out_if.hist_valid),
  .out_hist_count_i  (out_if.hist_count)
);

/* tb/fts_checker.sv */
// Checker that predicts each fan monitor result transaction and compares it field by field.
`timescale 1ns / 1ps
module fts_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  fts_pkg::cfg_reg_e         cfg_idx_i,
  input  logic [fts_pkg::REG_W-1:0] cfg_data_i,
  fts_in_if                         in_ch,
  fts_out_if                        out_ch,
  output int                        fail_count_o,
  output int                        pending_o
);
  import fts_pkg::*;

  logic [REG_W-1:0]   period_q;
  logic [REG_W-1:0]   start_power_q;
  logic [TICK_W-1:0]  tick_q;
  logic [PULSE_W-1:0] pulse_q;
  logic [US_W-1:0]    last_us_q;
  logic [SPEED_W-1:0] speed_q;
  logic [POWER_W-1:0] power_q;
  hist_entry_t        hist_q [HISTORY_DEPTH];
  logic [HIST_AW-1:0] head_q;
  int                 fill_q;
  out_item_t          expected_status_q [$];

  task automatic report_error(input string msg);
    if (fail_count_o < 200) begin
      $display("[%0t] fts_checker: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_fan_state();
    period_q      = REG_W'(SAMPLE_PERIOD_RST);
    start_power_q = REG_W'(START_POWER_RST);
    tick_q        = '0;
    pulse_q       = '0;
    last_us_q     = '0;
    speed_q       = '0;
    power_q       = '0;
    foreach (hist_q[i]) hist_q[i] = '0;
    head_q        = '0;
    fill_q        = 1;
    expected_status_q.delete();
  endtask

  // Pulses times the scale over the elapsed microseconds, saturated.
  task automatic update_speed(input logic [US_W-1:0] now_us);
    logic [US_W-1:0] interval;
    longint unsigned quot;
    interval  = now_us - last_us_q;
    last_us_q = now_us;
    if (interval == '0) begin
      speed_q = SPEED_W'(SPEED_MAX);
    end else begin
      quot = 64'(pulse_q) * 64'(SPEED_SCALE) / 64'(interval);
      speed_q = (quot > SPEED_MAX) ? SPEED_W'(SPEED_MAX) : quot[SPEED_W-1:0];
    end
    pulse_q = '0;
  endtask

  task automatic predict_status(output out_item_t status);
    int                 step;
    int                 age;
    int                 slot;
    logic [POWER_W-1:0] req;
    status = '0;
    case (in_ch.op)
      OP_TACH: begin
        if (in_ch.tach_low) pulse_q = pulse_q + 1'b1;
      end
      OP_TICK: begin
        tick_q = tick_q + 1'b1;
        step = int'(period_q) / PERIOD_DIVISOR;
        if (step == 0) step = 1;
        if (int'(tick_q) % step == 0) update_speed(in_ch.now_us);
        if (tick_q == period_q) begin
          tick_q = '0;
          head_q = head_q + 1'b1;
          hist_q[head_q].tstamp = in_ch.now_s;
          hist_q[head_q].speed  = speed_q;
          if (fill_q < HISTORY_DEPTH) fill_q++;
        end
      end
      OP_POWER: begin
        req = in_ch.power_request;
        if (req != '0 && speed_q < SLOW_SPEED && req < start_power_q) req = start_power_q;
        power_q = req;
      end
      default: begin
        age = int'(in_ch.history_index);
        if (age < fill_q) begin
          slot = (int'(head_q) + HISTORY_DEPTH - age) % HISTORY_DEPTH;
          status.hist_time  = hist_q[slot].tstamp;
          status.hist_speed = hist_q[slot].speed;
          status.hist_valid = 1'b1;
        end
      end
    endcase
    status.drive_power = power_q;
    status.speed_rpm   = speed_q;
    status.hist_count  = COUNT_W'((fill_q > COUNT_MAX) ? COUNT_MAX : fill_q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_fan_state();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SAMPLE_PERIOD: period_q = cfg_data_i;
          default:           start_power_q = cfg_data_i;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_status_q.size() == 0) begin
          report_error("result transaction with no request outstanding");
        end else begin
          want = expected_status_q.pop_front();
          check_field("drive_power", 32'(out_ch.drive_power), 32'(want.drive_power));
          check_field("speed_rpm", 32'(out_ch.speed_rpm), 32'(want.speed_rpm));
          check_field("hist_time", 32'(out_ch.hist_time), 32'(want.hist_time));
          check_field("hist_speed", 32'(out_ch.hist_speed), 32'(want.hist_speed));
          check_field("hist_valid", 32'(out_ch.hist_valid), 32'(want.hist_valid));
          check_field("hist_count", 32'(out_ch.hist_count), 32'(want.hist_count));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_status(want);
        expected_status_q.push_back(want);
      end
    end
    pending_o = expected_status_q.size();
  end

endmodule

/* tb/tb_fan_tach_speed_and_drive.sv */
// Testbench top that drives the fan monitor with directed and random transactions.
`timescale 1ns / 1ps
module tb_fan_tach_speed_and_drive;
  import fts_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 128;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_e         cfg_idx;
  logic [REG_W-1:0] cfg_data;

  fts_in_if  in_ch ();
  fts_out_if out_ch ();

  int              mismatches;
  int              pending_results;
  int              cycles;
  int              stall_left;
  bit              tx_steady;
  bit              rx_steady;
  logic [US_W-1:0] us_clock;
  logic [SEC_W-1:0] sec_clock;
  logic [REG_W-1:0] cur_start;

  fan_tach_speed_and_drive u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  fts_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (mismatches),
    .pending_o    (pending_results)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[fan_tach_speed_and_drive] ERROR");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls in random bursts unless a steady stretch is in force.
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  task automatic send_request(input op_e op, input logic tach, input logic [US_W-1:0] us,
                              input logic [SEC_W-1:0] secs, input logic [POWER_W-1:0] req,
                              input logic [AGE_W-1:0] age);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.tach_low      <= tach;
    in_ch.now_us        <= us;
    in_ch.now_s         <= secs;
    in_ch.power_request <= req;
    in_ch.history_index <= age;
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [REG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly tach pulses and speed ticks on a running clock, with reads and power requests.
  task automatic send_random_item();
    int                 pick;
    int                 r;
    op_e                op;
    logic               tach;
    logic [US_W-1:0]    us;
    logic [POWER_W-1:0] req;
    logic [AGE_W-1:0]   age;
    pick = $urandom_range(0, 99);
    tach = ($urandom_range(0, 9) != 0);
    us   = $urandom;
    req  = POWER_W'($urandom);
    age  = AGE_W'($urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 3));
    if ($urandom_range(0, 99) < 10) sec_clock = SEC_W'($urandom);
    else sec_clock = sec_clock + SEC_W'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (pick < 45) begin
      op = OP_TACH;
    end else if (pick < 75) begin
      op = OP_TICK;
      if (r < 70) us_clock = us_clock + $urandom_range(2000, 400000);
      else if (r < 78) us_clock = us_clock;
      else if (r < 85) us_clock = us_clock + $urandom_range(1, 50);
      else if (r < 92) us_clock = $urandom;
      else us_clock = us_clock + $urandom_range(1000000, 100000000);
      us = us_clock;
    end else if (pick < 87) begin
      op = OP_POWER;
      if (r < 30) req = POWER_W'($urandom_range(0, cur_start));
      else if (r < 40) req = '0;
      else if (r < 50) req = 16'd1;
      else if (r < 60) req = 16'hFFFF;
    end else begin
      op = OP_READ;
    end
    send_request(op, tach, us, sec_clock, req, age);
  endtask

  initial begin
    int               periods [PHASES];
    int               starts [PHASES];
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_TACH;
    in_ch.tach_low      = 1'b0;
    in_ch.now_us        = '0;
    in_ch.now_s         = '0;
    in_ch.power_request = '0;
    in_ch.history_index = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_SAMPLE_PERIOD;
    cfg_data  = '0;
    rst_n     = 1'b0;
    cycles    = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    us_clock  = '0;
    sec_clock = '0;
    periods   = '{10, 1, 2, 0, 13, 65535, 3, 100};
    starts    = '{0, 65535, 50, 1, 1000, 32767, $urandom_range(0, 65535), 50};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A period of one computes the speed and stores an entry on every tick.
    write_reg(CFG_SAMPLE_PERIOD, 16'd1);
    write_reg(CFG_START_POWER, 16'd50);
    cur_start = 16'd50;
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd0);
    send_request(OP_READ, 1'b1, '1, '1, '1, 6'd1);
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd63);
    send_request(OP_TACH, 1'b0, '1, '1, '1, 6'd63);
    repeat (3) send_request(OP_TACH, 1'b1, '0, '0, '0, '0);
    send_request(OP_TICK, 1'b0, 32'd0, 23'h7FFFFF, 16'hFFFF, 6'h3F);
    send_request(OP_TACH, 1'b1, '0, '0, '0, '0);
    send_request(OP_TICK, 1'b0, 32'd1, 23'd1, '0, '0);
    repeat (2) send_request(OP_TACH, 1'b1, '0, '0, '0, '0);
    send_request(OP_TICK, 1'b0, 32'd60001, 23'd2, '0, '0);
    send_request(OP_TICK, 1'b1, 32'hFFFF_FFFF, 23'd3, '0, '0);
    send_request(OP_TICK, 1'b0, 32'd5, 23'd4, '0, '0);
    send_request(OP_POWER, 1'b0, '0, '0, 16'd0, '0);
    send_request(OP_POWER, 1'b0, '0, '0, 16'd1, '0);
    send_request(OP_POWER, 1'b0, '0, '0, 16'd49, '0);
    send_request(OP_POWER, 1'b0, '0, '0, 16'd50, '0);
    send_request(OP_POWER, 1'b0, '0, '0, 16'hFFFF, '0);
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd0);
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd1);
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd2);
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd5);
    send_request(OP_READ, 1'b0, '0, '0, '0, 6'd63);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_SAMPLE_PERIOD, REG_W'(periods[p]));
      write_reg(CFG_START_POWER, REG_W'(starts[p]));
      cur_start = REG_W'(starts[p]);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) wait_idle();
        send_random_item();
      end
    end

    wait_idle();
    repeat (60) @(negedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("[fan_tach_speed_and_drive] OK");
    end else begin
      $display("[fan_tach_speed_and_drive] ERROR");
    end
    $finish;
  end

endmodule
